// ===== hw/rtl/mlfq_pkg.sv =====
//------------------------------------------------------------------------------
// mlfq_pkg: shared types and constants of the multilevel feedback scheduler
// Holds level/queue sizes, entry layout and the sequencer state type.
//------------------------------------------------------------------------------
`default_nettype none
package mlfq_pkg;
    localparam int MAX_LEVELS  = 4;
    localparam int FIFO_DEPTH  = 16;
    localparam int LVL_W       = $clog2(MAX_LEVELS);
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam int NL_W        = 3;
    localparam int ADDR_W      = LVL_W + PTR_W;
    localparam int DEPTH_ALL   = MAX_LEVELS * FIFO_DEPTH;

    localparam logic [0:0] REG_BASE_QUANTUM = 1'b0;
    localparam logic [0:0] REG_NUM_LEVELS   = 1'b1;
    localparam logic       MODE_ARRIVAL     = 1'b0;
    localparam logic       MODE_TICK        = 1'b1;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] rem;
        logic [15:0] used;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_READ,
        ST_LOAD,
        ST_DONE
    } t_state;
endpackage
`default_nettype wire

// ===== hw/rtl/multilevel_feedback_scheduler.sv =====
//------------------------------------------------------------------------------
// multilevel_feedback_scheduler: multilevel feedback queue task scheduler
//
// Input stream: tuser carries mode (0 queues a task at level 0, 1 advances
// the scheduler by one tick); tdata carries task_id and task_length. Every
// input item gives exactly one output item reporting the running task, a
// completion and a drop. Items are processed one at a time by a small
// sequencer around one entry memory. An arrival, or a tick that starts
// nothing, passes ST_DECIDE and ST_DONE before its result is registered; a
// tick that starts a queued task also passes ST_READ and ST_LOAD between
// them, as the memory read is registered. The next item is accepted no
// earlier than the cycle after the result is taken. o_s_tready is low while
// an item is in work or its result is not taken; a stalled receiver holds
// the result and the block. Queue writes land in the cycle after ST_DECIDE.
// Reset (synchronous, active low) empties all queues, clears the running
// task and restores base_quantum = 2, num_levels = 4.
// The entry memory needs no clearing: only written entries are ever read.
// Config writes are taken at any time but meant for idle periods.
//------------------------------------------------------------------------------
`default_nettype none
module multilevel_feedback_scheduler (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [0] mode
    input  wire logic [0:0]  i_s_tuser,
    // [15:0] task_id, [31:16] task_length
    input  wire logic [31:0] i_s_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [0] running_valid, [16:1] running_id, [17] finished_valid,
    // [33:18] finished_id, [34] dropped, [39:35] zero
    output logic [39:0]      o_m_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);
    localparam int L  = mlfq_pkg::MAX_LEVELS;
    localparam int LW = mlfq_pkg::LVL_W;
    localparam int PW = mlfq_pkg::PTR_W;
    localparam int CW = mlfq_pkg::CNT_W;

    mlfq_pkg::t_state r_state, n_state;

    logic [7:0]                 r_base;
    logic [mlfq_pkg::NL_W-1:0]  r_nl;
    logic [PW-1:0]              r_head  [L];
    logic [CW-1:0]              r_count [L];
    logic                       r_run_valid;
    logic [15:0]                r_run_id, r_run_rem, r_run_used;
    logic [LW-1:0]              r_run_level;
    logic                       r_preempt;
    logic                       r_mode;
    logic [15:0]                r_in_id, r_in_len;
    logic                       r_fin, r_drop;
    logic [15:0]                r_fin_id;
    logic [LW-1:0]              r_sel;
    logic                       r_out_valid;
    logic [39:0]                r_out_data;

    // memory port; the write is registered so a pop of the same slot reads
    // the old entry
    logic                       w_we, r_we;
    logic [mlfq_pkg::ADDR_W-1:0] w_waddr, w_raddr, r_waddr;
    mlfq_pkg::t_entry           w_wdata, w_rdata, r_wdata;

    mlfq_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (r_we),
        .i_waddr(r_waddr),
        .i_wdata(r_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // levels in use, last level index
    logic [mlfq_pkg::NL_W-1:0] w_nl;
    logic [LW-1:0]             w_last;
    always_comb begin
        if (r_nl < 3'd2) begin
            w_nl = 3'd2;
        end else if (r_nl > 3'(L)) begin
            w_nl = 3'(L);
        end else begin
            w_nl = r_nl;
        end
        w_last = LW'(w_nl - 3'd1);
    end

    // priority pick over levels in use (few levels, independent compares)
    logic          w_any;
    logic [LW-1:0] w_pick;
    always_comb begin
        w_any  = 1'b0;
        w_pick = '0;
        for (int i = L - 1; i >= 0; i--) begin
            if (3'(i) < w_nl && r_count[i] != '0) begin
                w_any  = 1'b1;
                w_pick = LW'(i);
            end
        end
    end

    // tick arithmetic
    logic [15:0] w_used_inc;
    logic [15:0] w_rem_dec;
    logic [23:0] w_quantum;
    logic        w_finish, w_expired, w_below_last;
    logic [LW:0] w_target;
    always_comb begin
        w_used_inc   = (r_run_used == 16'hFFFF) ? r_run_used : r_run_used + 16'd1;
        w_rem_dec    = r_run_rem - 16'd1;
        w_finish     = (r_run_rem <= 16'd1);
        w_quantum    = {16'd0, r_base} << r_run_level;
        w_expired    = ({8'd0, w_used_inc} >= w_quantum);
        w_below_last = (r_run_level < w_last);
        w_target     = {1'b0, r_run_level} + 1'b1;
    end

    // decide: actions of one item, taken in ST_DECIDE
    typedef struct packed {
        logic          push;
        logic          front;
        logic [LW-1:0] lvl;
        logic          start;
    } t_act;
    t_act w_act;
    always_comb begin
        w_act = '0;
        if (r_mode == mlfq_pkg::MODE_ARRIVAL) begin
            w_act.push = (r_count[0] < CW'(mlfq_pkg::FIFO_DEPTH));
            w_act.lvl  = '0;
        end else if (!r_run_valid || w_finish) begin
            w_act.start = w_any;
        end else if (w_below_last) begin
            if (w_expired && w_any) begin
                // the pop comes first, so a full target that is also the
                // picked level still has room
                w_act.start = 1'b1;
                w_act.lvl   = LW'(w_target);
                w_act.push  = (w_target < (LW+1)'(L))
                           && ((r_count[LW'(w_target)] < CW'(mlfq_pkg::FIFO_DEPTH))
                               || (w_pick == LW'(w_target)));
            end else if (r_preempt && r_run_level != '0
                         && r_count[r_run_level] < CW'(mlfq_pkg::FIFO_DEPTH)) begin
                w_act.push  = 1'b1;
                w_act.front = 1'b1;
                w_act.lvl   = r_run_level;
                w_act.start = 1'b1;
            end
        end
    end

    logic w_s_acc, w_m_acc;
    assign w_s_acc = i_s_tvalid && o_s_tready;
    assign w_m_acc = r_out_valid && i_m_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mlfq_pkg::ST_IDLE:   if (w_s_acc) n_state = mlfq_pkg::ST_DECIDE;
            mlfq_pkg::ST_DECIDE: n_state = w_act.start ? mlfq_pkg::ST_READ
                                                       : mlfq_pkg::ST_DONE;
            mlfq_pkg::ST_READ:   n_state = mlfq_pkg::ST_LOAD;
            mlfq_pkg::ST_LOAD:   n_state = mlfq_pkg::ST_DONE;
            mlfq_pkg::ST_DONE:   if (!r_out_valid || w_m_acc) n_state = mlfq_pkg::ST_IDLE;
            default:             n_state = mlfq_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    logic [PW-1:0] w_front_ptr;
    always_comb begin
        o_s_tready  = (r_state == mlfq_pkg::ST_IDLE) && !r_out_valid;
        w_front_ptr = r_head[w_act.lvl] - PW'(1);
        w_we        = (r_state == mlfq_pkg::ST_DECIDE) && w_act.push;
        w_waddr     = {w_act.lvl, w_act.front ? w_front_ptr
                                  : PW'(r_head[w_act.lvl] + PW'(r_count[w_act.lvl]))};
        w_wdata.id   = r_in_id;
        w_wdata.rem  = r_in_len;
        w_wdata.used = '0;
        if (r_mode != mlfq_pkg::MODE_ARRIVAL) begin
            w_wdata.id   = r_run_id;
            w_wdata.rem  = w_rem_dec;
            w_wdata.used = w_act.front ? w_used_inc : 16'd0;
        end
        w_raddr = {r_sel, r_head[r_sel]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mlfq_pkg::ST_IDLE;
            r_base      <= 8'd2;
            r_nl        <= 3'd4;
            r_run_valid <= 1'b0;
            r_run_id    <= '0;
            r_run_rem   <= '0;
            r_run_used  <= '0;
            r_run_level <= '0;
            r_preempt   <= 1'b0;
            r_out_valid <= 1'b0;
            r_sel       <= '0;
            r_we        <= 1'b0;
            for (int i = 0; i < L; i++) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_we    <= w_we;
            r_waddr <= w_waddr;
            r_wdata <= w_wdata;
            if (i_cfg_we) begin
                if (i_cfg_index == mlfq_pkg::REG_BASE_QUANTUM) r_base <= i_cfg_data;
                if (i_cfg_index == mlfq_pkg::REG_NUM_LEVELS)   r_nl   <= i_cfg_data[2:0];
            end
            if (w_m_acc && r_state != mlfq_pkg::ST_DONE) r_out_valid <= 1'b0;
            if (w_s_acc) begin
                r_mode   <= i_s_tuser[0];
                r_in_id  <= i_s_tdata[15:0];
                r_in_len <= i_s_tdata[31:16];
            end
            case (r_state)
                mlfq_pkg::ST_DECIDE: begin
                    r_sel <= w_pick;
                    if (w_act.push) begin
                        r_count[w_act.lvl] <= r_count[w_act.lvl] + CW'(1);
                        if (w_act.front) r_head[w_act.lvl] <= w_front_ptr;
                    end
                    if (r_mode == mlfq_pkg::MODE_ARRIVAL) begin
                        r_fin    <= 1'b0;
                        r_fin_id <= '0;
                        r_drop   <= !w_act.push;
                        if (w_act.push && r_run_valid && r_run_level != '0)
                            r_preempt <= 1'b1;
                    end else begin
                        r_preempt <= 1'b0;
                        r_fin     <= r_run_valid && w_finish;
                        r_fin_id  <= (r_run_valid && w_finish) ? r_run_id : 16'd0;
                        // only a demotion that finds no room drops here
                        r_drop    <= r_run_valid && !w_finish && w_act.start
                                     && !w_act.push;
                        if ((!r_run_valid || w_finish) && !w_any) begin
                            r_run_valid <= 1'b0;
                            r_run_id    <= '0;
                            r_run_rem   <= '0;
                            r_run_used  <= '0;
                            r_run_level <= '0;
                        end else if (r_run_valid) begin
                            r_run_used <= w_used_inc;
                            r_run_rem  <= w_finish ? 16'd0 : w_rem_dec;
                        end
                    end
                end
                mlfq_pkg::ST_READ: begin
                    r_head[r_sel]  <= r_head[r_sel] + PW'(1);
                    r_count[r_sel] <= r_count[r_sel] - CW'(1);
                end
                mlfq_pkg::ST_LOAD: begin
                    r_run_valid <= 1'b1;
                    r_run_id    <= w_rdata.id;
                    r_run_rem   <= w_rdata.rem;
                    r_run_used  <= w_rdata.used;
                    r_run_level <= r_sel;
                end
                mlfq_pkg::ST_DONE: begin
                    if (!r_out_valid || w_m_acc) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {5'd0, r_drop, r_fin_id, r_fin,
                                        r_run_valid ? r_run_id : 16'd0, r_run_valid};
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
endmodule
`default_nettype wire

// ===== hw/rtl/mlfq_ram.sv =====
//------------------------------------------------------------------------------
// mlfq_ram: task entry memory of all level queues
// One write port, one read port with registered read data.
//------------------------------------------------------------------------------
`default_nettype none
module mlfq_ram (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [mlfq_pkg::ADDR_W-1:0] i_waddr,
    input  wire mlfq_pkg::t_entry            i_wdata,
    input  wire logic [mlfq_pkg::ADDR_W-1:0] i_raddr,
    output mlfq_pkg::t_entry                 o_rdata
);
    mlfq_pkg::t_entry r_mem [mlfq_pkg::DEPTH_ALL];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/mlfq_checker.sv =====
//------------------------------------------------------------------------------
// mlfq_checker: port-level checks of the multilevel feedback scheduler
// Watches the stream ports and the result fields over time.
//------------------------------------------------------------------------------
`default_nettype none
module mlfq_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [39:0] o_m_tdata
);
    // one item in flight: no new input while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready) else $error("input taken with result pending");

    // an accepted item is not followed by another accept next cycle
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready) else $error("back to back accept");

    // idle report carries id zero
    a_idle_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[0]) |-> (o_m_tdata[16:1] == 16'd0))
        else $error("idle with nonzero id");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");
endmodule

bind multilevel_feedback_scheduler mlfq_checker u_mlfq_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata)
);
`default_nettype wire

// ===== verif/multilevel_feedback_scheduler_chk.sv =====
//------------------------------------------------------------------------------
// multilevel_feedback_scheduler_chk: scheduler result checker
// Watches the input and output streams and the config port, keeps its own
// model of the level queues and the running task, and compares every result.
//------------------------------------------------------------------------------
module multilevel_feedback_scheduler_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [0:0]  i_s_tuser,
    input  logic [31:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    mlfq_pkg::t_entry queue_mem [mlfq_pkg::MAX_LEVELS][mlfq_pkg::FIFO_DEPTH];
    int          q_head [mlfq_pkg::MAX_LEVELS];
    int          q_cnt [mlfq_pkg::MAX_LEVELS];
    logic        cur_valid;
    logic [15:0] cur_id, cur_rem, cur_used;
    int          cur_lvl;
    logic        preempt_flag;
    logic [7:0]  quantum_base;
    logic [2:0]  level_cfg;
    logic [34:0] sched_reports [$];
    int          errors = 0;
    int          pending_cnt = 0;

    assign o_errors  = errors;
    assign o_pending = pending_cnt;

    function automatic int active_levels();
        if (level_cfg < 2) return 2;
        if (level_cfg > mlfq_pkg::MAX_LEVELS) return mlfq_pkg::MAX_LEVELS;
        return int'(level_cfg);
    endfunction

    function automatic bit enqueue_tail(int lv, mlfq_pkg::t_entry e);
        if (lv >= mlfq_pkg::MAX_LEVELS || q_cnt[lv] >= mlfq_pkg::FIFO_DEPTH) return 0;
        queue_mem[lv][(q_head[lv] + q_cnt[lv]) % mlfq_pkg::FIFO_DEPTH] = e;
        q_cnt[lv]++;
        return 1;
    endfunction

    function automatic bit enqueue_head(int lv, mlfq_pkg::t_entry e);
        if (q_cnt[lv] >= mlfq_pkg::FIFO_DEPTH) return 0;
        q_head[lv] = (q_head[lv] + mlfq_pkg::FIFO_DEPTH - 1) % mlfq_pkg::FIFO_DEPTH;
        queue_mem[lv][q_head[lv]] = e;
        q_cnt[lv]++;
        return 1;
    endfunction

    function automatic bit someone_waiting();
        for (int i = 0; i < active_levels(); i++) if (q_cnt[i] != 0) return 1;
        return 0;
    endfunction

    function automatic void dispatch();
        mlfq_pkg::t_entry e;
        for (int i = 0; i < active_levels(); i++) begin
            if (q_cnt[i] != 0) begin
                e = queue_mem[i][q_head[i]];
                q_head[i] = (q_head[i] + 1) % mlfq_pkg::FIFO_DEPTH;
                q_cnt[i]--;
                cur_valid = 1; cur_id = e.id; cur_rem = e.rem;
                cur_used = e.used; cur_lvl = i;
                return;
            end
        end
        cur_valid = 0; cur_id = 0; cur_rem = 0; cur_used = 0; cur_lvl = 0;
    endfunction

    function automatic logic [34:0] schedule_item(logic mode, logic [15:0] id,
                                                  logic [15:0] len);
        logic             fin, drop;
        logic [15:0]      fin_id;
        int               last, tgt;
        mlfq_pkg::t_entry old;
        longint           quantum;
        fin = 0; drop = 0; fin_id = 0;
        if (mode == mlfq_pkg::MODE_ARRIVAL) begin
            if (!enqueue_tail(0, '{id: id, rem: len, used: 16'd0})) drop = 1;
            else if (cur_valid && cur_lvl > 0) preempt_flag = 1;
        end else if (!cur_valid) begin
            dispatch();
            preempt_flag = 0;
        end else begin
            last = active_levels() - 1;
            if (cur_used != 16'hFFFF) cur_used++;
            if (cur_rem <= 1) begin
                fin = 1; fin_id = cur_id;
                dispatch();
            end else begin
                cur_rem--;
                if (cur_lvl < last) begin
                    quantum = longint'(quantum_base) << cur_lvl;
                    if (cur_used >= quantum && someone_waiting()) begin
                        old = '{id: cur_id, rem: cur_rem, used: 16'd0};
                        tgt = cur_lvl + 1;
                        dispatch();
                        if (!enqueue_tail(tgt, old)) drop = 1;
                    end else if (preempt_flag && cur_lvl > 0) begin
                        old = '{id: cur_id, rem: cur_rem, used: cur_used};
                        if (enqueue_head(cur_lvl, old)) dispatch();
                    end
                end
            end
            preempt_flag = 0;
        end
        return {drop, fin_id, fin, cur_valid ? cur_id : 16'd0, cur_valid};
    endfunction

    always @(posedge i_clk) begin
        logic [34:0] want;
        if (!i_rst_n) begin
            for (int i = 0; i < mlfq_pkg::MAX_LEVELS; i++) begin
                q_head[i] = 0; q_cnt[i] = 0;
            end
            cur_valid = 0; cur_id = 0; cur_rem = 0; cur_used = 0; cur_lvl = 0;
            preempt_flag = 0; quantum_base = 8'd2; level_cfg = 3'd4;
            sched_reports.delete();
            pending_cnt = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == mlfq_pkg::REG_BASE_QUANTUM) quantum_base = i_cfg_data;
                else if (i_cfg_index == mlfq_pkg::REG_NUM_LEVELS)
                    level_cfg = i_cfg_data[2:0];
            end
            if (i_s_tvalid && i_s_tready)
                sched_reports.push_back(schedule_item(i_s_tuser[0], i_s_tdata[15:0],
                                                      i_s_tdata[31:16]));
            if (i_m_tvalid && i_m_tready) begin
                if (sched_reports.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %h", i_m_tdata);
                end else begin
                    want = sched_reports.pop_front();
                    if (i_m_tdata != {5'd0, want}) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: exp run %b/%h fin %b/%h drop %b,",
                                      " got run %b/%h fin %b/%h drop %b"},
                                     want[0], want[16:1], want[17], want[33:18],
                                     want[34], i_m_tdata[0], i_m_tdata[16:1],
                                     i_m_tdata[17], i_m_tdata[33:18], i_m_tdata[34]);
                    end
                end
            end
            pending_cnt = sched_reports.size();
        end
    end
endmodule

// ===== verif/multilevel_feedback_scheduler_tb.sv =====
//------------------------------------------------------------------------------
// multilevel_feedback_scheduler_tb: scheduler testbench top
// Drives arrivals and ticks with random gaps and back-pressure over several
// quantum / level settings; the checker compares every result.
//------------------------------------------------------------------------------
module multilevel_feedback_scheduler_tb;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [0:0]  s_user = '0;
    logic [31:0] s_data = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [39:0] m_data;
    logic        cfg_we = 0;
    logic [0:0]  cfg_index = mlfq_pkg::REG_BASE_QUANTUM;
    logic [7:0]  cfg_data = '0;
    int          errors, pending;
    bit          no_idle = 0;

    always #6 i_clk = ~i_clk;

    multilevel_feedback_scheduler i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .o_s_tready(s_ready), .i_s_tuser(s_user),
        .i_s_tdata(s_data),
        .o_m_tvalid(m_valid), .i_m_tready(m_ready), .o_m_tdata(m_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    multilevel_feedback_scheduler_chk i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .i_s_tready(s_ready), .i_s_tuser(s_user),
        .i_s_tdata(s_data),
        .i_m_tvalid(m_valid), .i_m_tready(m_ready), .i_m_tdata(m_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver back-pressure
    always @(posedge i_clk)
        m_ready <= no_idle || ($urandom_range(99) >= 24);

    // valid stays up after an accept unless an idle cycle follows
    task automatic send_item(logic mode, logic [15:0] id, logic [15:0] len);
        while (!no_idle && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= mode;
        s_data  <= {len, id};
        do @(posedge i_clk); while (!s_ready);
    endtask

    task automatic arrive(logic [15:0] id, logic [15:0] len);
        send_item(mlfq_pkg::MODE_ARRIVAL, id, len);
    endtask

    task automatic tick();
        send_item(mlfq_pkg::MODE_TICK, 16'($urandom), 16'($urandom));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [7:0] val);
        drain();
        repeat (8) @(posedge i_clk);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 0;
    endtask

    task automatic random_phase(int count, int arrive_pct, int max_len);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < arrive_pct)
                arrive(16'($urandom), $urandom_range(99) < 3 ? 16'($urandom) :
                                      16'($urandom_range(max_len)));
            else
                tick();
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: field extremes, zero length, full level 0, ticks
        arrive(16'hFFFF, 16'hFFFF);
        arrive(16'h0000, 16'h0000);
        arrive(16'hA5A5, 16'd1);
        tick(); tick(); tick(); tick();
        for (int k = 0; k < 17; k++) arrive(16'(k + 100), 16'd3);
        // zero quantum, two levels
        write_reg(mlfq_pkg::REG_BASE_QUANTUM, 8'd0);
        write_reg(mlfq_pkg::REG_NUM_LEVELS, 8'd2);
        random_phase(60, 45, 8);
        // out-of-range level counts, max quantum
        write_reg(mlfq_pkg::REG_NUM_LEVELS, 8'd0);
        write_reg(mlfq_pkg::REG_BASE_QUANTUM, 8'd255);
        random_phase(50, 40, 6);
        write_reg(mlfq_pkg::REG_NUM_LEVELS, 8'd7);
        write_reg(mlfq_pkg::REG_BASE_QUANTUM, 8'd1);
        no_idle = 1;
        random_phase(80, 50, 12);
        no_idle = 0;
        write_reg(mlfq_pkg::REG_NUM_LEVELS, 8'd3);
        write_reg(mlfq_pkg::REG_BASE_QUANTUM, 8'd2);
        random_phase(100, 55, 10);
        write_reg(mlfq_pkg::REG_NUM_LEVELS, 8'd4);
        write_reg(mlfq_pkg::REG_BASE_QUANTUM, 8'd1);
        random_phase(110, 35, 20);
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("multilevel_feedback_scheduler_tb passed");
        else
            $display("multilevel_feedback_scheduler_tb failed");
        $finish;
    end

    initial begin
        #3000000;
        $display("multilevel_feedback_scheduler_tb failed");
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/mlfq_pkg.sv
hw/rtl/mlfq_ram.sv
hw/rtl/multilevel_feedback_scheduler.sv
hw/rtl/mlfq_checker.sv
verif/multilevel_feedback_scheduler_chk.sv
verif/multilevel_feedback_scheduler_tb.sv
